/* design/stok_pkg.sv */
package stok_pkg;

    localparam int unsigned POS_BITS_DEF = 24;

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] start;
        logic [23:0] len;
        logic [23:0] line;
    } tok_t;

    // up to three tokens caused by one item, issued from index 0 upward
    typedef struct packed {
        logic [1:0]      cnt;
        tok_t [2:0]      tok;
    } grp_t;

    localparam logic [5:0] K_LPAREN   = 6'd0;
    localparam logic [5:0] K_RPAREN   = 6'd1;
    localparam logic [5:0] K_LBRACE   = 6'd2;
    localparam logic [5:0] K_RBRACE   = 6'd3;
    localparam logic [5:0] K_LBRACK   = 6'd4;
    localparam logic [5:0] K_RBRACK   = 6'd5;
    localparam logic [5:0] K_COMMA    = 6'd6;
    localparam logic [5:0] K_DOT      = 6'd7;
    localparam logic [5:0] K_MINUS    = 6'd8;
    localparam logic [5:0] K_PLUS     = 6'd9;
    localparam logic [5:0] K_SEMI     = 6'd10;
    localparam logic [5:0] K_STAR     = 6'd11;
    localparam logic [5:0] K_BANG     = 6'd12;
    localparam logic [5:0] K_SLASH    = 6'd20;
    localparam logic [5:0] K_STRING   = 6'd21;
    localparam logic [5:0] K_NUMBER   = 6'd22;
    localparam logic [5:0] K_IDENT    = 6'd23;
    localparam logic [5:0] K_KW_FIRST = 6'd24;
    localparam logic [5:0] K_EOF      = 6'd37;

    localparam int unsigned KW_COUNT = 13;

    // keyword text, first character in the low byte
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'("tni"), 48'("taolf"), 48'("loob"), 48'("rts"), 48'("fi"),
        48'("esle"), 48'("elihw"), 48'("rof"), 48'("nruter"), 48'("eurt"),
        48'("eslaf"), 48'("llun"), 48'("wen")
    };

    // unused high bytes of the buffer are always zero
    function automatic logic [5:0] word_kind(input logic [47:0] word, input logic [2:0] len);
        logic [5:0] k;
        k = K_IDENT;
        if (len <= 3'd6) begin
            for (int i = KW_COUNT - 1; i >= 0; i--) begin
                if (word == KW_TEXT[i]) begin
                    k = K_KW_FIRST + 6'(i);
                end
            end
        end
        return k;
    endfunction

endpackage

/* design/stok_scan.sv */
module stok_scan
    import stok_pkg::*;
#(
    parameter int unsigned POSITION_BITS = POS_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] byte_req,
    input  logic       q_free,
    output logic       q_load,
    output grp_t       q_grp
);

    typedef enum logic [3:0] {
        M_IDLE,
        M_OP,
        M_SLASH,
        M_COMMENT,
        M_STRING,
        M_NUMINT,
        M_NUMDOT,
        M_NUMFRAC,
        M_IDENT
    } mode_t;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam logic [1:0] OP_BANG = 2'd0;
    localparam logic [1:0] OP_EQ   = 2'd1;
    localparam logic [1:0] OP_LT   = 2'd2;
    localparam logic [1:0] OP_GT   = 2'd3;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    logic                     in_valid_reg;
    logic                     kind_reg;
    logic [7:0]               byte_reg;
    mode_t                    mode_reg,  mode_next;
    logic [POSITION_BITS-1:0] pos_reg,   pos_next;
    logic [POSITION_BITS-1:0] tok_begin_reg, tok_begin_next;
    logic [23:0]              line_reg,  line_next;
    logic [47:0]              word_reg,  word_next;
    logic [2:0]               wlen_reg,  wlen_next;
    logic [1:0]               pend_reg,  pend_next;

    logic                     advance;
    logic                     is_dig;
    logic                     is_alpha;
    logic                     do_flush;
    logic                     do_idle;
    logic [1:0]               n;
    logic [POSITION_BITS-1:0] len_run;
    logic [POSITION_BITS-1:0] len_int;
    logic [POSITION_BITS-1:0] len_str;
    logic [POSITION_BITS-1:0] dot_pos;
    logic [5:0]               op_kind;

    function automatic logic [23:0] fit(input logic [POSITION_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[23:0];
    endfunction

    function automatic tok_t mk(
        input logic [5:0]               k,
        input logic [POSITION_BITS-1:0] s,
        input logic [POSITION_BITS-1:0] l,
        input logic [23:0]              ln
    );
        tok_t t;
        t.kind  = k;
        t.start = fit(s);
        t.len   = fit(l);
        t.line  = ln;
        return t;
    endfunction

    assign advance  = in_valid_reg && q_free;
    assign in_ready = !in_valid_reg || advance;
    assign q_load   = advance;

    assign is_dig   = (byte_reg >= 8'h30) && (byte_reg <= 8'h39);
    assign is_alpha = ((byte_reg >= 8'h61) && (byte_reg <= 8'h7A))
                   || ((byte_reg >= 8'h41) && (byte_reg <= 8'h5A))
                   || (byte_reg == 8'h5F);

    assign len_run = pos_reg - tok_begin_reg;
    assign len_int = pos_reg - tok_begin_reg - POS_ONE;
    assign len_str = pos_reg - tok_begin_reg + POS_ONE;
    assign dot_pos = pos_reg - POS_ONE;
    assign op_kind = K_BANG + {3'b000, pend_reg, 1'b0};

    always_comb
    begin
        mode_next      = mode_reg;
        pos_next       = pos_reg + POS_ONE;
        tok_begin_next = tok_begin_reg;
        line_next      = line_reg;
        word_next      = word_reg;
        wlen_next      = wlen_reg;
        pend_next      = pend_reg;
        q_grp          = '0;
        n              = 2'd0;
        do_flush       = 1'b0;
        do_idle        = 1'b0;

        if (kind_reg) begin
            do_flush = 1'b1;
        end else begin
            unique case (mode_reg)
                M_OP:
                begin
                    if (byte_reg == CH_EQ) begin
                        q_grp.tok[n] = mk(op_kind + 6'd1, tok_begin_reg,
                                          POSITION_BITS'(2), line_reg);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (byte_reg == CH_SLASH) begin
                        mode_next = M_COMMENT;
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    do_idle = (byte_reg == CH_NL);
                end
                M_STRING:
                begin
                    if (byte_reg == CH_QUOTE) begin
                        q_grp.tok[n] = mk(K_STRING, tok_begin_reg, len_str, line_reg);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end else if (byte_reg == CH_NL && line_reg != LINE_MAX) begin
                        line_next = line_reg + 24'd1;
                    end
                end
                M_NUMINT:
                begin
                    if (byte_reg == CH_DOT) begin
                        mode_next = M_NUMDOT;
                    end else if (!is_dig) begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_NUMDOT:
                begin
                    if (is_dig) begin
                        mode_next = M_NUMFRAC;
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_NUMFRAC:
                begin
                    if (!is_dig) begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha || is_dig) begin
                        for (int i = 0; i < 6; i++) begin
                            if (3'(i) == wlen_reg) begin
                                word_next[8*i +: 8] = word_reg[8*i +: 8] | byte_reg;
                            end
                        end
                        if (wlen_reg != 3'd7) begin
                            wlen_next = wlen_reg + 3'd1;
                        end
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase
        end

        // finish the pending token, which ends just before this item
        if (do_flush) begin
            unique case (mode_reg)
                M_OP:
                begin
                    q_grp.tok[n] = mk(op_kind, tok_begin_reg, POS_ONE, line_reg);
                    n = n + 2'd1;
                end
                M_SLASH:
                begin
                    q_grp.tok[n] = mk(K_SLASH, tok_begin_reg, POS_ONE, line_reg);
                    n = n + 2'd1;
                end
                M_NUMINT, M_NUMFRAC:
                begin
                    q_grp.tok[n] = mk(K_NUMBER, tok_begin_reg, len_run, line_reg);
                    n = n + 2'd1;
                end
                M_NUMDOT:
                begin
                    q_grp.tok[n] = mk(K_NUMBER, tok_begin_reg, len_int, line_reg);
                    n = n + 2'd1;
                    q_grp.tok[n] = mk(K_DOT, dot_pos, POS_ONE, line_reg);
                    n = n + 2'd1;
                end
                M_IDENT:
                begin
                    q_grp.tok[n] = mk(word_kind(word_reg, wlen_reg), tok_begin_reg,
                                      len_run, line_reg);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            mode_next = M_IDLE;
        end

        // start of a new token from the idle state
        if (do_idle) begin
            mode_next = M_IDLE;
            unique case (byte_reg)
                CH_LPAREN: begin q_grp.tok[n] = mk(K_LPAREN, pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_RPAREN: begin q_grp.tok[n] = mk(K_RPAREN, pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_LBRACE: begin q_grp.tok[n] = mk(K_LBRACE, pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_RBRACE: begin q_grp.tok[n] = mk(K_RBRACE, pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_LBRACK: begin q_grp.tok[n] = mk(K_LBRACK, pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_RBRACK: begin q_grp.tok[n] = mk(K_RBRACK, pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_COMMA:  begin q_grp.tok[n] = mk(K_COMMA,  pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_DOT:    begin q_grp.tok[n] = mk(K_DOT,    pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_MINUS:  begin q_grp.tok[n] = mk(K_MINUS,  pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_PLUS:   begin q_grp.tok[n] = mk(K_PLUS,   pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_SEMI:   begin q_grp.tok[n] = mk(K_SEMI,   pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_STAR:   begin q_grp.tok[n] = mk(K_STAR,   pos_reg, POS_ONE, line_reg); n = n + 2'd1; end
                CH_BANG:
                begin
                    pend_next = OP_BANG;
                    mode_next = M_OP;
                    tok_begin_next = pos_reg;
                end
                CH_EQ:
                begin
                    pend_next = OP_EQ;
                    mode_next = M_OP;
                    tok_begin_next = pos_reg;
                end
                CH_LT:
                begin
                    pend_next = OP_LT;
                    mode_next = M_OP;
                    tok_begin_next = pos_reg;
                end
                CH_GT:
                begin
                    pend_next = OP_GT;
                    mode_next = M_OP;
                    tok_begin_next = pos_reg;
                end
                CH_SLASH:
                begin
                    mode_next = M_SLASH;
                    tok_begin_next = pos_reg;
                end
                CH_QUOTE:
                begin
                    mode_next = M_STRING;
                    tok_begin_next = pos_reg;
                end
                CH_NL:
                begin
                    if (line_reg != LINE_MAX) begin
                        line_next = line_reg + 24'd1;
                    end
                end
                default:
                begin
                    if (is_dig) begin
                        mode_next = M_NUMINT;
                        tok_begin_next = pos_reg;
                    end else if (is_alpha) begin
                        mode_next = M_IDENT;
                        word_next = {40'd0, byte_reg};
                        wlen_next = 3'd1;
                        tok_begin_next = pos_reg;
                    end
                end
            endcase
        end

        // end of source: closing token, then back to the reset state
        if (kind_reg) begin
            q_grp.tok[n]   = mk(K_EOF, pos_reg, '0, line_reg);
            n              = n + 2'd1;
            mode_next      = M_IDLE;
            pos_next       = '0;
            tok_begin_next = '0;
            line_next      = 24'd1;
            word_next      = '0;
            wlen_next      = 3'd0;
            pend_next      = 2'd0;
        end

        q_grp.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            mode_reg      <= M_IDLE;
            pos_reg       <= '0;
            tok_begin_reg <= '0;
            line_reg      <= 24'd1;
            word_reg      <= '0;
            wlen_reg      <= 3'd0;
            pend_reg      <= 2'd0;
        end else begin
            if (in_valid && in_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                mode_reg      <= mode_next;
                pos_reg       <= pos_next;
                tok_begin_reg <= tok_begin_next;
                line_reg      <= line_next;
                word_reg      <= word_next;
                wlen_reg      <= wlen_next;
                pend_reg      <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            kind_reg <= kind;
            byte_reg <= byte_req;
        end
    end

endmodule

/* design/stok_outq.sv */
module stok_outq
    import stok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    output logic        q_free,
    input  logic        q_load,
    input  grp_t        q_grp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [23:0] start_offset,
    output logic [23:0] token_length,
    output logic [23:0] line_number,
    output logic        last
);

    tok_t [2:0] tok_reg;
    logic [1:0] cnt_reg;
    logic [1:0] idx_reg;
    logic       pop;
    tok_t       cur;

    assign out_valid = (cnt_reg != 2'd0);
    assign last      = (idx_reg == cnt_reg - 2'd1);
    assign pop       = out_valid && out_ready;
    assign q_free    = !out_valid || (pop && last);

    assign cur          = tok_reg[idx_reg];
    assign token_kind   = cur.kind;
    assign start_offset = cur.start;
    assign token_length = cur.len;
    assign line_number  = cur.line;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            if (q_load) begin
                cnt_reg <= q_grp.cnt;
                idx_reg <= 2'd0;
            end else if (pop) begin
                if (last) begin
                    cnt_reg <= 2'd0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_load) begin
            tok_reg <= q_grp.tok;
        end
    end

endmodule

/* design/source_tokenizer.sv */
// an item is registered at the scanner input, its tokens in the output register
// throughput: one item per cycle, out_ready high and at most one token per item
// an item that yields several tokens holds the input side until the single output
// register has issued them all, one token per cycle while out_ready is high
// reset: asynchronous, active low; scanner state returns to idle, line 1, offset 0
module source_tokenizer
    import stok_pkg::*;
#(
    parameter int unsigned POSITION_BITS = POS_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  byte_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [23:0] start_offset,
    output logic [23:0] token_length,
    output logic [23:0] line_number,
    output logic        last
);

    logic q_free;
    logic q_load;
    grp_t q_grp;

    stok_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .byte_req (byte_req),
        .q_free   (q_free),
        .q_load   (q_load),
        .q_grp    (q_grp)
    );

    stok_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_free       (q_free),
        .q_load       (q_load),
        .q_grp        (q_grp),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .line_number  (line_number),
        .last         (last)
    );

endmodule

/* design/stok_check.sv */
module stok_check
    import stok_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  token_kind,
    input logic [23:0] start_offset,
    input logic [23:0] token_length,
    input logic [23:0] line_number,
    input logic        last
);

    // a stalled token holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind)
            && $stable(start_offset) && $stable(token_length) && $stable(last))
        else $error("stalled token changed");

    // end of source always closes the group of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_EOF |-> last && token_length == 24'd0)
        else $error("eof token malformed");

    // line count starts at one and saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line_number != 24'd0)
        else $error("line number zero");

    // an accepted end of source restarts line counting for later tokens
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && token_kind == K_EOF |=>
            !out_valid || token_kind == K_EOF || line_number == 24'd1
            || line_number == $past(line_number) || line_number < $past(line_number))
        else $error("line count not restarted after eof");

endmodule

bind source_tokenizer stok_check u_check (.*);

/* test/source_tokenizer_tb.sv */
module source_tokenizer_tb;

    import stok_pkg::*;

    localparam logic IN_BYTE = 1'b0;
    localparam logic IN_END  = 1'b1;

    localparam logic [1:0] OP_BANG = 2'd0;
    localparam logic [1:0] OP_EQ   = 2'd1;
    localparam logic [1:0] OP_LT   = 2'd2;
    localparam logic [1:0] OP_GT   = 2'd3;

    localparam logic [5:0] K_NE = K_BANG + 6'd1;

    localparam int DEMO_ROWS    = 25;
    localparam int RANDOM_ITEMS = 195;
    localparam int CALM_FROM    = 60;
    localparam int CALM_TO      = 130;
    localparam int HOLD_AT      = 180;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 50000;

    typedef enum logic [3:0]
    {
        SCAN_IDLE,
        SCAN_OP,
        SCAN_SLASH,
        SCAN_COMMENT,
        SCAN_STRING,
        SCAN_INT,
        SCAN_DOT,
        SCAN_FRAC,
        SCAN_WORD
    } scan_state_e;

    typedef struct packed
    {
        tok_t tok;
        logic last;
    } token_rec_t;

    typedef struct
    {
        logic        eos;
        logic [7:0]  ch;
        bit          typed;
        bit          has_tok;
        logic [5:0]  exp_kind;
        logic [23:0] exp_start;
        logic [23:0] exp_len;
        logic [23:0] exp_line;
    } src_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = IN_BYTE;
    logic [7:0]  byte_req = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  token_kind;
    logic [23:0] start_offset;
    logic [23:0] token_length;
    logic [23:0] line_number;
    logic        last;

    // scanner copy
    scan_state_e scan_mode;
    logic [23:0] scan_pos;
    logic [23:0] tok_start;
    logic [23:0] line_cnt;
    logic [47:0] word_buf;
    logic [2:0]  word_len;
    logic [1:0]  pend_op;
    token_rec_t  fresh_tokens [$];

    token_rec_t  pending_tokens [$];
    src_item_t   src_items [$];
    src_item_t   cur_item;

    bit          calm = 1'b0;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          errors = 0;
    int          random_count = 0;
    int          items_taken = 0;
    int          ends_taken = 0;
    int          tokens_checked = 0;
    int unsigned cycle_count = 0;

    string kw_words [13] = '{"int", "float", "bool", "str", "if", "else", "while",
                             "for", "return", "true", "false", "null", "new"};
    string alpha_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string op_chars    = "!=<>";
    string punct_chars = "(){}[],.-+;*";
    string space_chars = " \t\n\r";

    src_item_t demo_rows [DEMO_ROWS] = '{
        '{IN_BYTE, "(",   1, 1, K_LPAREN, 24'd0, 24'd1, 24'd1},
        '{IN_BYTE, "!",   1, 0, 0, 0, 0, 0},
        '{IN_BYTE, "=",   1, 1, K_NE, 24'd1, 24'd2, 24'd1},
        '{IN_BYTE, "<",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, "q",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, 8'hFF, 1, 1, K_IDENT, 24'd4, 24'd1, 24'd1},
        '{IN_BYTE, "1",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, ".",   0, 0, 0, 0, 0, 0},
        '{IN_END,  8'h00, 0, 0, 0, 0, 0, 0},
        '{IN_BYTE, "\"",  0, 0, 0, 0, 0, 0},
        '{IN_BYTE, "\n",  0, 0, 0, 0, 0, 0},
        '{IN_END,  8'hA5, 1, 1, K_EOF, 24'd2, 24'd0, 24'd2},
        '{IN_BYTE, "/",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, "/",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, 8'h80, 0, 0, 0, 0, 0, 0},
        '{IN_END,  8'h5A, 1, 1, K_EOF, 24'd3, 24'd0, 24'd1},
        '{IN_BYTE, "n",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, "e",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, "w",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, ";",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, "2",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, ".",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, "5",   0, 0, 0, 0, 0, 0},
        '{IN_BYTE, 8'h00, 0, 0, 0, 0, 0, 0},
        '{IN_END,  8'h7E, 0, 0, 0, 0, 0, 0}
    };

    source_tokenizer i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .byte_req     (byte_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .line_number  (line_number),
        .last         (last)
    );

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic void clear_scanner();
        scan_mode = SCAN_IDLE;
        scan_pos  = '0;
        tok_start = '0;
        line_cnt  = 24'd1;
        word_buf  = '0;
        word_len  = '0;
        pend_op   = OP_BANG;
    endfunction

    function automatic void add_token(logic [5:0] k, logic [23:0] s, logic [23:0] n);
        token_rec_t r;
        r.tok.kind  = k;
        r.tok.start = s;
        r.tok.len   = n;
        r.tok.line  = line_cnt;
        r.last      = 1'b0;
        fresh_tokens.push_back(r);
    endfunction

    function automatic logic [5:0] word_class();
        logic [47:0] text;
        logic [5:0]  found;
        found = K_IDENT;
        if (word_len <= 3'd6)
        begin
            for (int i = 0; i < 13; i++)
            begin
                text = '0;
                for (int j = 0; j < kw_words[i].len(); j++)
                    text[8*j +: 8] = kw_words[i][j];
                if (found == K_IDENT && kw_words[i].len() == word_len && text == word_buf)
                    found = K_KW_FIRST + 6'(i);
            end
        end
        return found;
    endfunction

    function automatic logic [5:0] op_code(logic [1:0] op, bit with_eq);
        return K_BANG + 6'(op) * 6'd2 + 6'(with_eq);
    endfunction

    function automatic void close_token();
        case (scan_mode)
            SCAN_OP:
                add_token(op_code(pend_op, 1'b0), tok_start, 24'd1);
            SCAN_SLASH:
                add_token(K_SLASH, tok_start, 24'd1);
            SCAN_INT, SCAN_FRAC:
                add_token(K_NUMBER, tok_start, scan_pos - tok_start);
            SCAN_DOT:
            begin
                add_token(K_NUMBER, tok_start, scan_pos - 24'd1 - tok_start);
                add_token(K_DOT, scan_pos - 24'd1, 24'd1);
            end
            SCAN_WORD:
                add_token(word_class(), tok_start, scan_pos - tok_start);
            default:
                ;
        endcase
        scan_mode = SCAN_IDLE;
    endfunction

    function automatic void open_token(logic [7:0] c);
        scan_mode = SCAN_IDLE;
        case (c)
            "(": add_token(K_LPAREN, scan_pos, 24'd1);
            ")": add_token(K_RPAREN, scan_pos, 24'd1);
            "{": add_token(K_LBRACE, scan_pos, 24'd1);
            "}": add_token(K_RBRACE, scan_pos, 24'd1);
            "[": add_token(K_LBRACK, scan_pos, 24'd1);
            "]": add_token(K_RBRACK, scan_pos, 24'd1);
            ",": add_token(K_COMMA, scan_pos, 24'd1);
            ".": add_token(K_DOT, scan_pos, 24'd1);
            "-": add_token(K_MINUS, scan_pos, 24'd1);
            "+": add_token(K_PLUS, scan_pos, 24'd1);
            ";": add_token(K_SEMI, scan_pos, 24'd1);
            "*": add_token(K_STAR, scan_pos, 24'd1);
            "!", "=", "<", ">":
            begin
                pend_op   = (c == "!") ? OP_BANG : (c == "=") ? OP_EQ :
                            (c == "<") ? OP_LT : OP_GT;
                scan_mode = SCAN_OP;
                tok_start = scan_pos;
            end
            "/":
            begin
                scan_mode = SCAN_SLASH;
                tok_start = scan_pos;
            end
            "\"":
            begin
                scan_mode = SCAN_STRING;
                tok_start = scan_pos;
            end
            "\n":
                if (line_cnt != LINE_MAX)
                    line_cnt++;
            default:
                if (is_digit(c))
                begin
                    scan_mode = SCAN_INT;
                    tok_start = scan_pos;
                end
                else if (is_alpha(c))
                begin
                    scan_mode = SCAN_WORD;
                    tok_start = scan_pos;
                    word_buf  = {40'd0, c};
                    word_len  = 3'd1;
                end
        endcase
    endfunction

    function automatic void scan_item(logic eos, logic [7:0] c);
        fresh_tokens.delete();
        if (eos == IN_END)
        begin
            close_token();
            add_token(K_EOF, scan_pos, 24'd0);
            clear_scanner();
        end
        else
        begin
            case (scan_mode)
                SCAN_OP:
                    if (c == "=")
                    begin
                        add_token(op_code(pend_op, 1'b1), tok_start, 24'd2);
                        scan_mode = SCAN_IDLE;
                    end
                    else
                    begin
                        close_token();
                        open_token(c);
                    end
                SCAN_SLASH:
                    if (c == "/")
                        scan_mode = SCAN_COMMENT;
                    else
                    begin
                        close_token();
                        open_token(c);
                    end
                SCAN_COMMENT:
                    if (c == "\n")
                        open_token(c);
                SCAN_STRING:
                    if (c == "\"")
                    begin
                        add_token(K_STRING, tok_start, scan_pos + 24'd1 - tok_start);
                        scan_mode = SCAN_IDLE;
                    end
                    else if (c == "\n" && line_cnt != LINE_MAX)
                        line_cnt++;
                SCAN_INT:
                    if (c == ".")
                        scan_mode = SCAN_DOT;
                    else if (!is_digit(c))
                    begin
                        close_token();
                        open_token(c);
                    end
                SCAN_DOT:
                    if (is_digit(c))
                        scan_mode = SCAN_FRAC;
                    else
                    begin
                        close_token();
                        open_token(c);
                    end
                SCAN_FRAC:
                    if (!is_digit(c))
                    begin
                        close_token();
                        open_token(c);
                    end
                SCAN_WORD:
                    if (is_alpha(c) || is_digit(c))
                    begin
                        if (word_len < 3'd6)
                            word_buf[8*word_len +: 8] = c;
                        if (word_len < 3'd7)
                            word_len++;
                    end
                    else
                    begin
                        close_token();
                        open_token(c);
                    end
                default:
                    open_token(c);
            endcase
            scan_pos++;
        end
        if (fresh_tokens.size() != 0)
            fresh_tokens[$].last = 1'b1;
    endfunction

    task automatic flag_error(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        errors++;
    endtask

    task automatic push_byte(logic [7:0] c, bit counted);
        src_item_t it;
        it = '{default: '0};
        it.eos = IN_BYTE;
        it.ch  = c;
        src_items.push_back(it);
        if (counted)
            random_count++;
    endtask

    task automatic push_end();
        src_item_t it;
        it = '{default: '0};
        it.eos = IN_END;
        it.ch  = 8'($urandom_range(0, 255));
        src_items.push_back(it);
        random_count++;
    endtask

    task automatic push_digit();
        push_byte(8'("0" + $urandom_range(0, 9)), 1'b1);
    endtask

    task automatic push_fragment();
        string word;
        int    n;
        case ($urandom_range(0, 11))
            0:
            begin
                word = kw_words[$urandom_range(0, 12)];
                for (int i = 0; i < word.len(); i++)
                    push_byte(word[i], 1'b1);
            end
            1:
            begin
                n = $urandom_range(1, 10);
                push_byte(alpha_chars[$urandom_range(0, alpha_chars.len() - 1)], 1'b1);
                for (int i = 1; i < n; i++)
                    if ($urandom_range(0, 3) == 0)
                        push_digit();
                    else
                        push_byte(alpha_chars[$urandom_range(0, alpha_chars.len() - 1)], 1'b1);
            end
            2:
            begin
                repeat ($urandom_range(1, 4))
                    push_digit();
                case ($urandom_range(0, 3))
                    0:
                    begin
                        push_byte(".", 1'b1);
                        repeat ($urandom_range(1, 3))
                            push_digit();
                    end
                    1:
                        push_byte(".", 1'b1);
                    default:
                        ;
                endcase
            end
            3:
            begin
                push_byte("\"", 1'b1);
                repeat ($urandom_range(0, 6))
                    push_byte(($urandom_range(0, 5) == 0) ? "\n" : 8'($urandom_range(32, 126)),
                              1'b1);
                if ($urandom_range(0, 9) == 0)
                    push_end();
                else
                    push_byte("\"", 1'b1);
            end
            4:
            begin
                push_byte(op_chars[$urandom_range(0, 3)], 1'b1);
                if ($urandom_range(0, 1) == 0)
                    push_byte("=", 1'b1);
            end
            5:
            begin
                push_byte("/", 1'b1);
                push_byte("/", 1'b1);
                repeat ($urandom_range(0, 5))
                    push_byte(8'($urandom_range(0, 255)), 1'b1);
                push_byte("\n", 1'b1);
            end
            6:
                push_byte("/", 1'b1);
            7:
                push_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)], 1'b1);
            8, 9:
                push_byte(space_chars[$urandom_range(0, 3)], 1'b1);
            10:
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            default:
                if ($urandom_range(0, 2) == 0)
                    push_end();
                else
                    push_byte("\n", 1'b1);
        endcase
    endtask

    task automatic note_item(src_item_t it);
        token_rec_t r;
        scan_item(it.eos, it.ch);
        if (it.typed)
        begin
            if (it.has_tok)
            begin
                r.tok.kind  = it.exp_kind;
                r.tok.start = it.exp_start;
                r.tok.len   = it.exp_len;
                r.tok.line  = it.exp_line;
                r.last      = 1'b1;
                pending_tokens.push_back(r);
            end
        end
        else
        begin
            foreach (fresh_tokens[i])
                pending_tokens.push_back(fresh_tokens[i]);
        end
        items_taken++;
        if (it.eos == IN_END)
            ends_taken++;
    endtask

    initial
    begin
        forever
            #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("source_tokenizer_tb: done, errors");
        $finish;
    end

    // receiver, with one long hold-off that backs the block up
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    always @(posedge clk)
    begin : monitor
        token_rec_t want;
        if (rst_n && in_valid && in_ready)
            note_item(cur_item);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tokens.size() == 0)
                flag_error("token with none pending, kind", token_kind, 0);
            else
            begin
                want = pending_tokens.pop_front();
                tokens_checked++;
                if (token_kind !== want.tok.kind)
                    flag_error("token_kind", token_kind, want.tok.kind);
                if (start_offset !== want.tok.start)
                    flag_error("start_offset", start_offset, want.tok.start);
                if (token_length !== want.tok.len)
                    flag_error("token_length", token_length, want.tok.len);
                if (line_number !== want.tok.line)
                    flag_error("line_number", line_number, want.tok.line);
                if (last !== want.last)
                    flag_error("last", last, want.last);
            end
        end
    end

    initial
    begin
        clear_scanner();
        cur_item = '{default: '0};
        foreach (demo_rows[i])
            src_items.push_back(demo_rows[i]);
        while (random_count < RANDOM_ITEMS)
        begin
            push_fragment();
            if ($urandom_range(0, 9) < 6)
                push_byte(space_chars[$urandom_range(0, 3)], 1'b1);
        end
        push_end();

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (src_items[i])
        begin
            calm = (i >= CALM_FROM && i < CALM_TO);
            if (i == HOLD_AT)
                hold_go = 1'b1;
            while (!calm && $urandom_range(0, 99) < 13)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            kind     <= src_items[i].eos;
            byte_req <= src_items[i].ch;
            cur_item <= src_items[i];
            do
                @(posedge clk);
            while (!in_ready);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (pending_tokens.size() != 0)
            flag_error("tokens never seen", pending_tokens.size(), 0);

        $display("run covered %0d items with %0d end markers, %0d tokens checked",
                 items_taken, ends_taken, tokens_checked);
        $display("stimulus mixed keywords, words, numbers, strings, comments and noise bytes");
        if (errors == 0)
            $display("source_tokenizer_tb: done, clean");
        else
            $display("source_tokenizer_tb: done, errors");
        $finish;
    end

endmodule
